// ----- rtl/core/ipfm_pkg.sv -----
package ipfm_pkg;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam int PREFIX_MAX = 32;
    localparam int ADDR_W     = 32;
    localparam int PLEN_W     = 6;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] address;
        logic [PLEN_W-1:0] prefix_len;
        logic              allow;
    } t_in_item;

    typedef struct packed {
        logic permit;
        logic matched;
        logic pool_full;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_STEP = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

// ----- rtl/core/ipfm_node_ram.sv -----
module ipfm_node_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/ip_prefix_first_match_filter.sv -----
// IPv4 first-match access list held as a binary trie. An add item walks the
// trie along the address bits, most significant first, allocating nodes from a
// pool, and marks the target node only if no rule already covers it; a query
// item walks as deep as the trie reaches and returns the verdict of the deepest
// marked node, or allow with matched low. An item visits 1 to 33 trie levels,
// one per step of its walk, which is paced by the node memory: it gives one
// registered read per cycle. A finished item is held back only while the
// result before it is still stalled on the output.
// The next item is accepted while the previous result waits on the output.
// The root lives in flip-flops and every other node is cleared when it is
// allocated, so no clearing pass is needed after reset. When the pool runs dry
// during an add, pool_full is reported and the rule is not placed.
module ip_prefix_first_match_filter #(
    parameter int NODE_COUNT = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  ipfm_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output ipfm_pkg::t_out_item o_item
);

    localparam int AW = $clog2(NODE_COUNT);
    localparam int NW = 2 * AW + 2;
    localparam logic [AW:0] NODE_LIMIT = (AW + 1)'(NODE_COUNT);
    localparam logic [ipfm_pkg::PLEN_W-1:0] PLEN_MAX =
        ipfm_pkg::PLEN_W'(ipfm_pkg::PREFIX_MAX);

    ipfm_pkg::t_state r_state, n_state;

    logic                          r_cmd, n_cmd;
    logic [ipfm_pkg::ADDR_W-1:0]   r_addr, n_addr;
    logic [ipfm_pkg::PLEN_W-1:0]   r_plen, n_plen;
    logic                          r_allow, n_allow;
    logic [ipfm_pkg::PLEN_W-1:0]   r_depth, n_depth;
    logic [AW-1:0]                 r_pos, n_pos;
    logic [AW:0]                   r_used, n_used;
    logic [NW-1:0]                 r_cur, n_cur;
    logic                          r_from_mem, n_from_mem;
    logic [NW-1:0]                 r_root, n_root;
    logic                          r_permit, n_permit;
    logic                          r_matched, n_matched;
    logic                          r_full, n_full;
    logic                          r_out_valid, n_out_valid;
    ipfm_pkg::t_out_item           r_out, n_out;

    logic [NW-1:0] rd_data;
    logic [NW-1:0] cur;
    logic [NW-1:0] linked_word;
    logic [NW-1:0] marked_word;
    logic [AW-1:0] c_child;
    logic          c_marked;
    logic          c_allow;
    logic          c_at_target;
    logic          c_last;
    logic          pool_empty;
    logic          word_we;
    logic [NW-1:0] word_data;
    logic          rd_en;
    logic          wr_en;

    ipfm_node_ram #(
        .WIDTH(NW),
        .DEPTH(NODE_COUNT)
    ) u_node_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_pos),
        .i_wr_data(word_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(c_child),
        .o_rd_data(rd_data)
    );

    assign cur         = r_from_mem ? rd_data : r_cur;
    assign c_marked    = cur[1];
    assign c_allow     = cur[0];
    assign c_child     = r_addr[ipfm_pkg::ADDR_W-1] ? cur[NW-1 -: AW] : cur[NW-1-AW -: AW];
    assign c_at_target = (r_depth == r_plen);
    assign c_last      = (r_depth == PLEN_MAX);
    assign pool_empty  = (r_used >= NODE_LIMIT);
    assign marked_word = {cur[NW-1:2], 1'b1, r_allow};
    assign linked_word = r_addr[ipfm_pkg::ADDR_W-1] ?
        {r_used[AW-1:0], cur[NW-1-AW:0]} :
        {cur[NW-1 -: AW], r_used[AW-1:0], cur[1:0]};
    assign wr_en       = word_we && (r_pos != '0);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_addr      = r_addr;
        n_plen      = r_plen;
        n_allow     = r_allow;
        n_depth     = r_depth;
        n_pos       = r_pos;
        n_used      = r_used;
        n_cur       = r_cur;
        n_from_mem  = r_from_mem;
        n_root      = r_root;
        n_permit    = r_permit;
        n_matched   = r_matched;
        n_full      = r_full;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        word_we     = 1'b0;
        word_data   = cur;
        rd_en       = 1'b0;

        unique case (r_state)
            ipfm_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_cmd      = i_item.command;
                    n_addr     = i_item.address;
                    n_plen     = (i_item.prefix_len > PLEN_MAX) ? PLEN_MAX : i_item.prefix_len;
                    n_allow    = i_item.allow;
                    n_depth    = '0;
                    n_pos      = '0;
                    n_cur      = r_root;
                    n_from_mem = 1'b0;
                    n_permit   = (i_item.command == ipfm_pkg::CMD_QUERY);
                    n_matched  = 1'b0;
                    n_full     = 1'b0;
                    n_state    = ipfm_pkg::S_STEP;
                end
            end
            ipfm_pkg::S_STEP: begin
                if (r_cmd == ipfm_pkg::CMD_QUERY) begin
                    if (c_marked) begin
                        n_permit  = c_allow;
                        n_matched = 1'b1;
                    end
                    if (c_last || c_child == '0) begin
                        n_state = ipfm_pkg::S_DONE;
                    end else begin
                        rd_en      = 1'b1;
                        n_pos      = c_child;
                        n_from_mem = 1'b1;
                        n_depth    = r_depth + 1'b1;
                        n_addr     = r_addr << 1;
                    end
                end else begin
                    priority if (c_at_target) begin
                        word_we   = 1'b1;
                        word_data = c_marked ? cur : marked_word;
                        n_state   = ipfm_pkg::S_DONE;
                    end else if (c_marked) begin
                        n_state = ipfm_pkg::S_DONE;
                    end else if (c_child != '0) begin
                        rd_en      = 1'b1;
                        n_pos      = c_child;
                        n_from_mem = 1'b1;
                        n_depth    = r_depth + 1'b1;
                        n_addr     = r_addr << 1;
                    end else if (pool_empty) begin
                        word_we   = 1'b1;
                        word_data = cur;
                        n_full    = 1'b1;
                        n_state   = ipfm_pkg::S_DONE;
                    end else begin
                        word_we    = 1'b1;
                        word_data  = linked_word;
                        n_cur      = '0;
                        n_from_mem = 1'b0;
                        n_pos      = r_used[AW-1:0];
                        n_used     = r_used + 1'b1;
                        n_depth    = r_depth + 1'b1;
                        n_addr     = r_addr << 1;
                    end
                end
                if (word_we && r_pos == '0) begin
                    n_root = word_data;
                end
            end
            ipfm_pkg::S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid       = 1'b1;
                    n_out.permit      = r_permit;
                    n_out.matched     = r_matched;
                    n_out.pool_full   = r_full;
                    n_state           = ipfm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ipfm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ipfm_pkg::S_IDLE;
            r_used      <= (AW + 1)'(1);
            r_root      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_root      <= n_root;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_addr     <= n_addr;
        r_plen     <= n_plen;
        r_allow    <= n_allow;
        r_depth    <= n_depth;
        r_pos      <= n_pos;
        r_cur      <= n_cur;
        r_from_mem <= n_from_mem;
        r_permit   <= n_permit;
        r_matched  <= n_matched;
        r_full     <= n_full;
        r_out      <= n_out;
    end

    assign o_stall = (r_state != ipfm_pkg::S_IDLE);
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

// ----- rtl/core/ipfm_checker.sv -----
module ipfm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input ipfm_pkg::t_out_item o_item
);

    // A result that is held back keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_item)))
        else $error("stalled output item changed");

    // An accepted item leaves the idle state, so it always busies the block.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted twice in a row");

    // An add that ran out of nodes carries no verdict.
    a_full_no_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.pool_full) |-> (!o_item.permit && !o_item.matched))
        else $error("pool_full item carries a verdict");

    // No result is presented right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind ip_prefix_first_match_filter ipfm_checker u_ipfm_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_stall(o_stall),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_item (o_item)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int NODE_COUNT   = 4096;
    localparam int RANDOM_ITEMS = 1860;
    localparam int STUCK_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int DIR_ROWS     = 25;

    localparam ipfm_pkg::t_out_item RES_ADDED     = '{1'b0, 1'b0, 1'b0};
    localparam ipfm_pkg::t_out_item RES_DEFAULT   = '{1'b1, 1'b0, 1'b0};
    localparam ipfm_pkg::t_out_item RES_ALLOW_HIT = '{1'b1, 1'b1, 1'b0};
    localparam ipfm_pkg::t_out_item RES_DENY_HIT  = '{1'b0, 1'b1, 1'b0};
    localparam ipfm_pkg::t_out_item RES_ANY       = '{1'b0, 1'b0, 1'b0};

    typedef struct packed {
        ipfm_pkg::t_in_item  item;
        logic                typed;
        ipfm_pkg::t_out_item want;
    } t_dir_row;

    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{'{ipfm_pkg::CMD_QUERY, 32'h00000000, 6'd0,  1'b0}, 1'b1, RES_DEFAULT},
        '{'{ipfm_pkg::CMD_QUERY, 32'hFFFFFFFF, 6'd0,  1'b0}, 1'b1, RES_DEFAULT},
        '{'{ipfm_pkg::CMD_ADD,   32'hFFFFFFFF, 6'd32, 1'b0}, 1'b1, RES_ADDED},
        '{'{ipfm_pkg::CMD_QUERY, 32'hFFFFFFFF, 6'd0,  1'b0}, 1'b1, RES_DENY_HIT},
        '{'{ipfm_pkg::CMD_QUERY, 32'hFFFFFFFE, 6'd0,  1'b0}, 1'b1, RES_DEFAULT},
        '{'{ipfm_pkg::CMD_ADD,   32'hC0A80000, 6'd16, 1'b1}, 1'b1, RES_ADDED},
        '{'{ipfm_pkg::CMD_QUERY, 32'hC0A81234, 6'd0,  1'b0}, 1'b1, RES_ALLOW_HIT},
        '{'{ipfm_pkg::CMD_ADD,   32'hC0A81200, 6'd24, 1'b0}, 1'b1, RES_ADDED},
        '{'{ipfm_pkg::CMD_QUERY, 32'hC0A81234, 6'd0,  1'b0}, 1'b1, RES_ALLOW_HIT},
        '{'{ipfm_pkg::CMD_QUERY, 32'hC0A8FF00, 6'd0,  1'b0}, 1'b1, RES_ALLOW_HIT},
        '{'{ipfm_pkg::CMD_ADD,   32'hC0A81200, 6'd24, 1'b1}, 1'b1, RES_ADDED},
        '{'{ipfm_pkg::CMD_QUERY, 32'hC0A812FF, 6'd0,  1'b0}, 1'b1, RES_ALLOW_HIT},
        '{'{ipfm_pkg::CMD_ADD,   32'hC0A8F000, 6'd20, 1'b0}, 1'b1, RES_ADDED},
        '{'{ipfm_pkg::CMD_QUERY, 32'hC0A8F001, 6'd0,  1'b0}, 1'b1, RES_ALLOW_HIT},
        '{'{ipfm_pkg::CMD_ADD,   32'h00000001, 6'd63, 1'b0}, 1'b1, RES_ADDED},
        '{'{ipfm_pkg::CMD_QUERY, 32'h00000001, 6'd0,  1'b0}, 1'b1, RES_DENY_HIT},
        '{'{ipfm_pkg::CMD_QUERY, 32'h00000000, 6'd0,  1'b0}, 1'b1, RES_DEFAULT},
        '{'{ipfm_pkg::CMD_ADD,   32'h00000002, 6'd33, 1'b1}, 1'b1, RES_ADDED},
        '{'{ipfm_pkg::CMD_QUERY, 32'h00000002, 6'd0,  1'b0}, 1'b1, RES_ALLOW_HIT},
        '{'{ipfm_pkg::CMD_QUERY, 32'h00000003, 6'd0,  1'b0}, 1'b1, RES_DEFAULT},
        '{'{ipfm_pkg::CMD_ADD,   32'hAAAAAAAA, 6'd31, 1'b1}, 1'b0, RES_ANY},
        '{'{ipfm_pkg::CMD_QUERY, 32'hAAAAAAAB, 6'd0,  1'b0}, 1'b0, RES_ANY},
        '{'{ipfm_pkg::CMD_ADD,   32'h0A000000, 6'd8,  1'b0}, 1'b0, RES_ANY},
        '{'{ipfm_pkg::CMD_QUERY, 32'h0AFFFFFF, 6'd0,  1'b0}, 1'b0, RES_ANY},
        '{'{ipfm_pkg::CMD_QUERY, 32'h55555555, 6'd0,  1'b0}, 1'b0, RES_ANY}
    };

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    ipfm_pkg::t_in_item  i_item  = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    ipfm_pkg::t_out_item o_item;

    bit                  steady = 1'b0;
    int                  mismatches = 0;
    int                  results_seen = 0;
    int                  stuck_cycles = 0;
    ipfm_pkg::t_out_item oldest;
    ipfm_pkg::t_out_item verdict_q[$];
    logic [31:0]         rule_addrs[$];

    logic [11:0] link_zero [NODE_COUNT];
    logic [11:0] link_one  [NODE_COUNT];
    bit          rule_set  [NODE_COUNT];
    bit          rule_pass [NODE_COUNT];
    int          trie_used;

    ip_prefix_first_match_filter #(
        .NODE_COUNT(NODE_COUNT)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_item (i_item),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_item (o_item)
    );

    always #10 i_clk = ~i_clk;

    function automatic ipfm_pkg::t_out_item acl_verdict(input ipfm_pkg::t_in_item it);
        ipfm_pkg::t_out_item res;
        int                  node;
        int                  nxt;
        int                  depth;
        int                  plen;
        logic                b;
        res  = '0;
        node = 0;
        if (it.command == ipfm_pkg::CMD_QUERY) begin
            res.permit = 1'b1;
            for (depth = 0; depth <= ipfm_pkg::PREFIX_MAX; depth++) begin
                if (rule_set[node]) begin
                    res.permit  = rule_pass[node];
                    res.matched = 1'b1;
                end
                if (depth == ipfm_pkg::PREFIX_MAX) break;
                b   = it.address[ipfm_pkg::ADDR_W-1-depth];
                nxt = b ? int'(link_one[node]) : int'(link_zero[node]);
                if (nxt == 0) break;
                node = nxt;
            end
        end else begin
            plen = (it.prefix_len > ipfm_pkg::PREFIX_MAX) ? ipfm_pkg::PREFIX_MAX
                                                          : int'(it.prefix_len);
            for (depth = 0; depth < plen; depth++) begin
                if (rule_set[node]) return res;
                b   = it.address[ipfm_pkg::ADDR_W-1-depth];
                nxt = b ? int'(link_one[node]) : int'(link_zero[node]);
                if (nxt == 0) begin
                    if (trie_used >= NODE_COUNT) begin
                        res.pool_full = 1'b1;
                        return res;
                    end
                    nxt = trie_used;
                    trie_used++;
                    link_zero[nxt] = '0;
                    link_one[nxt]  = '0;
                    rule_set[nxt]  = 1'b0;
                    rule_pass[nxt] = 1'b0;
                    if (b) begin
                        link_one[node] = nxt[11:0];
                    end else begin
                        link_zero[node] = nxt[11:0];
                    end
                end
                node = nxt;
            end
            if (!rule_set[node]) begin
                rule_set[node]  = 1'b1;
                rule_pass[node] = it.allow;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 100) begin
            $display("MISMATCH result %0d %s: got %0d, expected %0d",
                     results_seen, what, got, want);
        end
        mismatches++;
    endtask

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_item(input ipfm_pkg::t_in_item it, input logic typed,
                             input ipfm_pkg::t_out_item want);
        ipfm_pkg::t_out_item pred;
        while (!steady && $urandom_range(99) < 16) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pred = acl_verdict(it);
        verdict_q.push_back(typed ? want : pred);
    endtask

    always @(posedge i_clk) begin
        i_stall <= !steady && ($urandom_range(99) < 16);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("with nothing pending", int'(o_item), 0);
            end else begin
                oldest = verdict_q.pop_front();
                if (o_item.permit !== oldest.permit)
                    report_mismatch("permit", int'(o_item.permit), int'(oldest.permit));
                if (o_item.matched !== oldest.matched)
                    report_mismatch("matched", int'(o_item.matched), int'(oldest.matched));
                if (o_item.pool_full !== oldest.pool_full)
                    report_mismatch("pool_full", int'(o_item.pool_full),
                                    int'(oldest.pool_full));
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", STUCK_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        ipfm_pkg::t_in_item it;
        int                 n;
        int                 keep;
        int                 pick;
        logic [31:0]        mask;
        for (n = 0; n < NODE_COUNT; n++) begin
            link_zero[n] = '0;
            link_one[n]  = '0;
            rule_set[n]  = 1'b0;
            rule_pass[n] = 1'b0;
        end
        trie_used = 1;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < DIR_ROWS; n++) begin
            send_item(DIRECTED[n].item, DIRECTED[n].typed, DIRECTED[n].want);
        end

        // Most items probe or extend the neighborhood of rules already placed.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            steady        = (n >= 700 && n < 1000);
            it.command    = ($urandom_range(99) < 45) ? ipfm_pkg::CMD_ADD : ipfm_pkg::CMD_QUERY;
            it.address    = $urandom;
            it.prefix_len = ipfm_pkg::PLEN_W'($urandom_range(63));
            it.allow      = 1'($urandom_range(1));
            if (rule_addrs.size() != 0 && $urandom_range(99) < 60) begin
                keep       = $urandom_range(32);
                mask       = (keep == 0) ? 32'h0 : ~32'h0 << (32 - keep);
                it.address = (rule_addrs[$urandom_range(rule_addrs.size() - 1)] & mask)
                           | (it.address & ~mask);
            end
            if (it.command == ipfm_pkg::CMD_ADD) begin
                pick = $urandom_range(99);
                if (pick < 2) begin
                    it.prefix_len = ipfm_pkg::PLEN_W'($urandom_range(7, 1));
                end else if (pick < 6) begin
                    it.prefix_len = ipfm_pkg::PLEN_W'($urandom_range(63, 33));
                end else if (pick < 30) begin
                    it.prefix_len = ipfm_pkg::PLEN_W'($urandom_range(23, 8));
                end else begin
                    it.prefix_len = ipfm_pkg::PLEN_W'($urandom_range(32, 24));
                end
                rule_addrs.push_back(it.address);
                if (rule_addrs.size() > 48) void'(rule_addrs.pop_front());
            end
            send_item(it, 1'b0, RES_ANY);
        end
        steady = 1'b0;

        // A zero-length rule covers everything, so it comes after the random items.
        it = '{ipfm_pkg::CMD_ADD, 32'h00000000, 6'd0, 1'b0};
        send_item(it, 1'b1, RES_ADDED);
        for (n = 0; n < 12; n++) begin
            it.command    = ($urandom_range(3) == 0) ? ipfm_pkg::CMD_ADD : ipfm_pkg::CMD_QUERY;
            it.address    = $urandom;
            it.prefix_len = ipfm_pkg::PLEN_W'($urandom_range(32));
            it.allow      = 1'($urandom_range(1));
            send_item(it, 1'b0, RES_ANY);
        end
        i_valid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
